FILE: design/smr_pkg.sv
// Shared types and constants of the shape mask rasterizer.
package smr_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned ALPHA_W = 8;
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [MODE_W-1:0]  mode_t;

    // Shape mode codes
    localparam mode_t MODE_PRECISE = 3'd0;
    localparam mode_t MODE_ELLIPSE = 3'd1;
    localparam mode_t MODE_DIAMOND = 3'd2;
    localparam mode_t MODE_CIRCLE  = 3'd3;
    localparam mode_t MODE_NONE    = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BBOX_LEFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BBOX_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BBOX_RIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BBOX_BOTTOM  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

    // Reset values
    localparam size_t IMAGE_SIZE_RESET = 13'd4096;

    // Window widening around the box, in pixels
    localparam logic [COORD_W:0] WIN_MARGIN = 13'd2;

endpackage

FILE: design/shape_mask_rasterizer_top.sv
// Shape mask rasterizer: four-stage pipeline giving one collision-mask bit per pixel.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel per beat: pixel_x, pixel_y, alpha.
//   Output channel (out_valid/out_ready) carries one result per beat: mask_bit, has_mask.
//   Configuration port (cfg_we/cfg_index/cfg_data) writes one register per cycle:
//   0 shape_mode, 1..4 box left/top/right/bottom, 5 image_width, 6 image_height.
//   Indexes above 6 are ignored. Write only while no pixel is in flight.
// Path: an accepted beat passes the stage registers s1, s2, s3 and s4 before it is
//   shown on the output; four registers sit on the path.
// Throughput: one pixel per cycle while out_ready stays high; the work is split
//   over four stages (setup, squares and cross products, shape products, final compare).
// Stalls: each stage has its own valid bit and loads when it is empty or its
//   successor moves, so bubbles collapse and up to four beats are held while
//   out_ready is low; nothing is dropped or repeated.
// Reset: rst_n clears all valid bits and loads shape_mode 4 (no mask), box edges 0
//   and image size 4096.
module shape_mask_rasterizer_top
    import smr_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_W-1:0]    pixel_x,
    input  logic [COORD_W-1:0]    pixel_y,
    input  logic [ALPHA_W-1:0]    alpha,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  mask_bit,
    output logic                  has_mask
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    mode_t  shape_mode_reg;
    coord_t bbox_left_reg, bbox_top_reg, bbox_right_reg, bbox_bottom_reg;
    size_t  image_width_reg, image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg   <= MODE_NONE;
            bbox_left_reg    <= '0;
            bbox_top_reg     <= '0;
            bbox_right_reg   <= '0;
            bbox_bottom_reg  <= '0;
            image_width_reg  <= IMAGE_SIZE_RESET;
            image_height_reg <= IMAGE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHAPE_MODE:   shape_mode_reg   <= cfg_data[MODE_W-1:0];
                REG_BBOX_LEFT:    bbox_left_reg    <= cfg_data[COORD_W-1:0];
                REG_BBOX_TOP:     bbox_top_reg     <= cfg_data[COORD_W-1:0];
                REG_BBOX_RIGHT:   bbox_right_reg   <= cfg_data[COORD_W-1:0];
                REG_BBOX_BOTTOM:  bbox_bottom_reg  <= cfg_data[COORD_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
                default:          ; // unused index: write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: stage i loads when empty or when stage i+1 moves
    // ---------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;
    logic s1_load, s2_load, s3_load, s4_load;

    assign s4_ready = !s4_valid_reg || out_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_load = in_valid && s1_ready;
    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;
    assign s4_load = s3_valid_reg && s4_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) s1_valid_reg <= in_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (s3_ready) s3_valid_reg <= s2_valid_reg;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: window test, center offsets, radii, diamond operands
    // ---------------------------------------------------------------
    coord_t xc, yc;
    coord_t box_w, box_h;
    logic   win_x, win_y;

    mode_t               s1_mode_next;
    logic                s1_alpha_nz_next, s1_inwin_next;
    coord_t              s1_adx_next, s1_ady_next;
    logic [COORD_W-2:0]  s1_rx_next, s1_ry_next, s1_rad_next;
    logic signed [COORD_W:0] s1_lpx_next, s1_rpx_next, s1_py_next;
    logic signed [COORD_W:0] s1_exl_next, s1_exr_next, s1_ety_next, s1_eby_next;

    mode_t               s1_mode_reg;
    logic                s1_alpha_nz_reg, s1_inwin_reg;
    coord_t              s1_adx_reg, s1_ady_reg;
    logic [COORD_W-2:0]  s1_rx_reg, s1_ry_reg, s1_rad_reg;
    logic signed [COORD_W:0] s1_lpx_reg, s1_rpx_reg, s1_py_reg;
    logic signed [COORD_W:0] s1_exl_reg, s1_exr_reg, s1_ety_reg, s1_eby_reg;

    always_comb
    begin
        logic [COORD_W:0] sum_lr, sum_tb;
        sum_lr = {1'b0, bbox_left_reg} + {1'b0, bbox_right_reg};
        sum_tb = {1'b0, bbox_top_reg} + {1'b0, bbox_bottom_reg};
        xc     = sum_lr[COORD_W:1];
        yc     = sum_tb[COORD_W:1];
        // differences only matter when the box is not inverted
        box_w  = bbox_right_reg - bbox_left_reg;
        box_h  = bbox_bottom_reg - bbox_top_reg;

        // left bound max(l-2,0) <= x rewritten as x+2 >= l
        win_x = ({1'b0, pixel_x} + WIN_MARGIN >= {1'b0, bbox_left_reg})
             && ({1'b0, pixel_x} < {1'b0, bbox_right_reg} + WIN_MARGIN)
             && ({1'b0, pixel_x} < image_width_reg)
             && (32'(pixel_x) < 32'(MAX_DIM));
        win_y = ({1'b0, pixel_y} + WIN_MARGIN >= {1'b0, bbox_top_reg})
             && ({1'b0, pixel_y} < {1'b0, bbox_bottom_reg} + WIN_MARGIN)
             && ({1'b0, pixel_y} < image_height_reg)
             && (32'(pixel_y) < 32'(MAX_DIM));

        s1_mode_next     = shape_mode_reg;
        s1_alpha_nz_next = (alpha != '0);
        s1_inwin_next    = (bbox_right_reg >= bbox_left_reg)
                        && (bbox_bottom_reg >= bbox_top_reg) && win_x && win_y;
        s1_adx_next      = (pixel_x >= xc) ? pixel_x - xc : xc - pixel_x;
        s1_ady_next      = (pixel_y >= yc) ? pixel_y - yc : yc - pixel_y;
        s1_rx_next       = box_w[COORD_W-1:1];
        s1_ry_next       = box_h[COORD_W-1:1];
        s1_rad_next      = (box_w < box_h) ? box_w[COORD_W-1:1] : box_h[COORD_W-1:1];

        s1_lpx_next = $signed({1'b0, pixel_x}) - $signed({1'b0, bbox_left_reg});
        s1_rpx_next = $signed({1'b0, pixel_x}) - $signed({1'b0, bbox_right_reg});
        s1_py_next  = $signed({1'b0, pixel_y}) - $signed({1'b0, yc});
        s1_exl_next = $signed({1'b0, xc}) - $signed({1'b0, bbox_left_reg});
        s1_exr_next = $signed({1'b0, xc}) - $signed({1'b0, bbox_right_reg});
        s1_ety_next = $signed({1'b0, bbox_top_reg}) - $signed({1'b0, yc});
        s1_eby_next = $signed({1'b0, bbox_bottom_reg}) - $signed({1'b0, yc});
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_mode_reg     <= s1_mode_next;
            s1_alpha_nz_reg <= s1_alpha_nz_next;
            s1_inwin_reg    <= s1_inwin_next;
            s1_adx_reg      <= s1_adx_next;
            s1_ady_reg      <= s1_ady_next;
            s1_rx_reg       <= s1_rx_next;
            s1_ry_reg       <= s1_ry_next;
            s1_rad_reg      <= s1_rad_next;
            s1_lpx_reg      <= s1_lpx_next;
            s1_rpx_reg      <= s1_rpx_next;
            s1_py_reg       <= s1_py_next;
            s1_exl_reg      <= s1_exl_next;
            s1_exr_reg      <= s1_exr_next;
            s1_ety_reg      <= s1_ety_next;
            s1_eby_reg      <= s1_eby_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: squares and the six cross-product terms
    // ---------------------------------------------------------------
    localparam int unsigned SQ_W  = 2 * COORD_W;        // |d|^2
    localparam int unsigned RSQ_W = 2 * (COORD_W - 1);  // radius^2
    localparam int unsigned XP_W  = 2 * (COORD_W + 1);  // signed cross term

    mode_t                 s2_mode_reg;
    logic                  s2_alpha_nz_reg, s2_inwin_reg;
    logic [SQ_W-1:0]       s2_dx2_reg, s2_dy2_reg;
    logic [RSQ_W-1:0]      s2_rx2_reg, s2_ry2_reg, s2_rad2_reg;
    logic signed [XP_W-1:0] s2_lpx_ety_reg, s2_lpx_eby_reg, s2_exl_py_reg;
    logic signed [XP_W-1:0] s2_rpx_ety_reg, s2_rpx_eby_reg, s2_exr_py_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_mode_reg     <= s1_mode_reg;
            s2_alpha_nz_reg <= s1_alpha_nz_reg;
            s2_inwin_reg    <= s1_inwin_reg;
            s2_dx2_reg      <= SQ_W'(s1_adx_reg) * SQ_W'(s1_adx_reg);
            s2_dy2_reg      <= SQ_W'(s1_ady_reg) * SQ_W'(s1_ady_reg);
            s2_rx2_reg      <= RSQ_W'(s1_rx_reg) * RSQ_W'(s1_rx_reg);
            s2_ry2_reg      <= RSQ_W'(s1_ry_reg) * RSQ_W'(s1_ry_reg);
            s2_rad2_reg     <= RSQ_W'(s1_rad_reg) * RSQ_W'(s1_rad_reg);
            s2_lpx_ety_reg  <= XP_W'(s1_lpx_reg) * XP_W'(s1_ety_reg);
            s2_lpx_eby_reg  <= XP_W'(s1_lpx_reg) * XP_W'(s1_eby_reg);
            s2_exl_py_reg   <= XP_W'(s1_exl_reg) * XP_W'(s1_py_reg);
            s2_rpx_ety_reg  <= XP_W'(s1_rpx_reg) * XP_W'(s1_ety_reg);
            s2_rpx_eby_reg  <= XP_W'(s1_rpx_reg) * XP_W'(s1_eby_reg);
            s2_exr_py_reg   <= XP_W'(s1_exr_reg) * XP_W'(s1_py_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: ellipse products, circle and diamond decisions
    // ---------------------------------------------------------------
    localparam int unsigned EP_W = SQ_W + RSQ_W;   // ry^2 * dx^2
    localparam int unsigned ER_W = 2 * RSQ_W;      // rx^2 * ry^2

    logic s3_circ_next, s3_diam_next;

    always_comb
    begin
        logic signed [XP_W:0] c1, c2, c3, c4;
        c1 = (XP_W+1)'(s2_lpx_ety_reg) - (XP_W+1)'(s2_exl_py_reg);
        c2 = (XP_W+1)'(s2_lpx_eby_reg) - (XP_W+1)'(s2_exl_py_reg);
        c3 = (XP_W+1)'(s2_rpx_ety_reg) - (XP_W+1)'(s2_exr_py_reg);
        c4 = (XP_W+1)'(s2_rpx_eby_reg) - (XP_W+1)'(s2_exr_py_reg);
        // edge points count as inside
        s3_diam_next = (c1 <= 0) && (c2 >= 0) && (c3 >= 0) && (c4 <= 0);
        s3_circ_next = ((SQ_W+1)'(s2_dx2_reg) + (SQ_W+1)'(s2_dy2_reg))
                    <= (SQ_W+1)'(s2_rad2_reg);
    end

    mode_t            s3_mode_reg;
    logic             s3_alpha_nz_reg, s3_inwin_reg, s3_circ_reg, s3_diam_reg;
    logic [EP_W-1:0]  s3_ell_a_reg, s3_ell_b_reg;
    logic [ER_W-1:0]  s3_ell_r_reg;

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_mode_reg     <= s2_mode_reg;
            s3_alpha_nz_reg <= s2_alpha_nz_reg;
            s3_inwin_reg    <= s2_inwin_reg;
            s3_circ_reg     <= s3_circ_next;
            s3_diam_reg     <= s3_diam_next;
            s3_ell_a_reg    <= EP_W'(s2_ry2_reg) * EP_W'(s2_dx2_reg);
            s3_ell_b_reg    <= EP_W'(s2_rx2_reg) * EP_W'(s2_dy2_reg);
            s3_ell_r_reg    <= ER_W'(s2_rx2_reg) * ER_W'(s2_ry2_reg);
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: ellipse compare, mode select, output register
    // ---------------------------------------------------------------
    logic s4_mask_next, s4_has_next;
    logic ell_in;

    always_comb
    begin
        ell_in = ((EP_W+1)'(s3_ell_a_reg) + (EP_W+1)'(s3_ell_b_reg))
              <= (EP_W+1)'(s3_ell_r_reg);
        s4_mask_next = 1'b0;
        s4_has_next  = 1'b1;
        unique case (s3_mode_reg)
            MODE_PRECISE: s4_mask_next = s3_alpha_nz_reg;
            MODE_ELLIPSE: s4_mask_next = s3_inwin_reg && ell_in;
            MODE_DIAMOND: s4_mask_next = s3_inwin_reg && s3_diam_reg;
            MODE_CIRCLE:  s4_mask_next = s3_inwin_reg && s3_circ_reg;
            default:      s4_has_next  = 1'b0; // no mask and unused codes
        endcase
    end

    logic s4_mask_reg, s4_has_reg;

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            s4_mask_reg <= s4_mask_next;
            s4_has_reg  <= s4_has_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign mask_bit  = s4_mask_reg;
    assign has_mask  = s4_has_reg;

endmodule

FILE: design/smr_checker.sv
// Port-level checker for the shape mask rasterizer, with its bind.
module smr_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic mask_bit,
    input logic has_mask
);

    // no result is shown in the first cycle after reset is released
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("out_valid high right after reset");

    // a draining output never blocks the input side
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    // a set mask bit only comes from a mode that has a mask
    a_mask_has: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mask_bit) |-> has_mask)
        else $error("mask_bit set without has_mask");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("out_valid dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(mask_bit) && $stable(has_mask)))
        else $error("output beat changed while stalled");

endmodule

bind shape_mask_rasterizer_top smr_checker u_smr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mask_bit  (mask_bit),
    .has_mask  (has_mask)
);
